FILE: design/vc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the varint codec.
// No dependencies; every other file refers to this package by scoped names.
package vc_pkg;

	localparam int MAX_GROUPS  = 5;
	localparam int GROUP_BITS  = 7;
	localparam int BYTE_W      = 8;
	localparam int VALUE_W     = 32;
	localparam int ACC_W       = 35;
	localparam int CNT_W       = 3;
	localparam int KIND_W      = 2;
	localparam int GC_W        = $clog2(MAX_GROUPS + 1);
	localparam int SH_W        = $clog2(GROUP_BITS * MAX_GROUPS + 1);
	localparam int ENC_MAX     = (VALUE_W + GROUP_BITS - 1) / GROUP_BITS;
	localparam int EK_W        = $clog2(ENC_MAX + 1);
	localparam int ESH_W       = $clog2(GROUP_BITS * ENC_MAX + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
	localparam int                CONT_POS   = 7;

	typedef enum logic {
		OP_DECODE = 1'b0,
		OP_ENCODE = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_VALUE = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		op_t                op;
		logic [BYTE_W-1:0]  in_byte;
		logic [VALUE_W-1:0] in_value;
		logic [EK_W-1:0]    nbytes;
	} cmd_t;

endpackage

FILE: design/vc_if.sv
`timescale 1ns / 1ps
// Handshake channels of the varint codec: input items, result words, configuration.
// Depends on vc_pkg for field widths.
interface vc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [vc_pkg::BYTE_W-1:0]   in_byte;
	logic [vc_pkg::VALUE_W-1:0]  in_value;

	modport source (output valid, operation, in_byte, in_value, input ready);
	modport sink (input valid, operation, in_byte, in_value, output ready);
endinterface

interface vc_out_if;
	logic                        valid;
	logic                        ready;
	logic [vc_pkg::KIND_W-1:0]   out_kind;
	logic [vc_pkg::VALUE_W-1:0]  out_value;
	logic [vc_pkg::BYTE_W-1:0]   out_byte;
	logic [vc_pkg::CNT_W-1:0]    byte_count;
	logic                        last;

	modport source (output valid, out_kind, out_value, out_byte, byte_count, last,
		input ready);
	modport sink (input valid, out_kind, out_value, out_byte, byte_count, last,
		output ready);
endinterface

interface vc_cfg_if;
	logic valid;
	logic ready;
	logic signed_mode;

	modport source (output valid, signed_mode, input ready);
	modport sink (input valid, signed_mode, output ready);
endinterface

FILE: design/vc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words and turns them into queue commands.
// Depends on vc_pkg and vc_in_if.
module vc_front (
	vc_in_if.sink           items,
	input  logic            full,
	output logic            push,
	output vc_pkg::cmd_t    push_cmd
);

	logic [vc_pkg::EK_W-1:0] nbytes;

	always_comb begin
		nbytes = vc_pkg::EK_W'(1);
		for (int i = 1; i < vc_pkg::ENC_MAX; i++) begin
			if ((items.in_value >> (vc_pkg::GROUP_BITS * i)) != '0) begin
				nbytes = vc_pkg::EK_W'(i + 1);
			end
		end
	end

	assign items.ready       = !full;
	assign push              = items.valid && !full;
	assign push_cmd.op       = vc_pkg::op_t'(items.operation);
	assign push_cmd.in_byte  = items.in_byte;
	assign push_cmd.in_value = items.in_value;
	assign push_cmd.nbytes   = nbytes;

endmodule

FILE: design/vc_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on vc_pkg.
module vc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vc_pkg::cmd_t    push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output vc_pkg::cmd_t    head
);

	vc_pkg::cmd_t              mem_q [vc_pkg::QUEUE_DEPTH];
	logic [vc_pkg::QPTR_W-1:0] wr_q;
	logic [vc_pkg::QPTR_W-1:0] rd_q;
	logic [vc_pkg::QPTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	assign full       = count_q == (vc_pkg::QPTR_W + 1)'(vc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (vc_pkg::QPTR_W + 1)'(vc_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
`endif

endmodule

FILE: design/vc_back.sv
`timescale 1ns / 1ps
// Back end: decoder state, byte-per-cycle encoder when unstalled; drives results.
// Depends on vc_pkg, vc_out_if and the head of vc_queue.
module vc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            signed_mode,
	input  logic            head_valid,
	input  vc_pkg::cmd_t    head,
	output logic            pop,
	vc_out_if.source        results
);

	logic [vc_pkg::ACC_W-1:0]   acc_q;
	logic [vc_pkg::GC_W-1:0]    gc_q;
	logic [vc_pkg::EK_W-1:0]    k_q;
	logic                       res_valid_q;
	vc_pkg::kind_t              kind_q;
	logic [vc_pkg::VALUE_W-1:0] value_q;
	logic [vc_pkg::BYTE_W-1:0]  byte_q;
	logic [vc_pkg::CNT_W-1:0]   cnt_q;
	logic                       last_q;

	logic                       step;
	logic                       over;
	logic [vc_pkg::SH_W-1:0]    dec_sh;
	logic [vc_pkg::ACC_W-1:0]   acc_or;
	logic [vc_pkg::VALUE_W-1:0] plain;
	logic [vc_pkg::VALUE_W-1:0] decoded;
	logic [vc_pkg::ESH_W-1:0]   enc_sh;
	logic [vc_pkg::BYTE_W-1:0]  grp;
	logic                       enc_last;

	logic                       emit;
	logic                       done;
	logic [vc_pkg::ACC_W-1:0]   acc_d;
	logic [vc_pkg::GC_W-1:0]    gc_d;
	logic [vc_pkg::EK_W-1:0]    k_d;
	vc_pkg::kind_t              kind_d;
	logic [vc_pkg::VALUE_W-1:0] value_d;
	logic [vc_pkg::BYTE_W-1:0]  byte_d;
	logic [vc_pkg::CNT_W-1:0]   cnt_d;
	logic                       last_d;

	assign step    = head_valid && (!res_valid_q || results.ready);
	assign over    = gc_q >= vc_pkg::GC_W'(vc_pkg::MAX_GROUPS);
	assign dec_sh  = vc_pkg::SH_W'(gc_q) * vc_pkg::SH_W'(vc_pkg::GROUP_BITS);
	assign acc_or  = acc_q
		| (vc_pkg::ACC_W'(head.in_byte & vc_pkg::GROUP_MASK) << dec_sh);
	assign plain   = acc_or[vc_pkg::VALUE_W-1:0];
	assign decoded = signed_mode
		? ({1'b0, plain[vc_pkg::VALUE_W-1:1]} ^ {vc_pkg::VALUE_W{plain[0]}})
		: plain;

	assign enc_sh   = vc_pkg::ESH_W'(k_q) * vc_pkg::ESH_W'(vc_pkg::GROUP_BITS);
	assign grp      = vc_pkg::BYTE_W'(head.in_value >> enc_sh) & vc_pkg::GROUP_MASK;
	assign enc_last = k_q == (head.nbytes - 1'b1);

	always_comb begin
		emit    = 1'b0;
		done    = 1'b0;
		acc_d   = acc_q;
		gc_d    = gc_q;
		k_d     = k_q;
		kind_d  = vc_pkg::KIND_VALUE;
		value_d = '0;
		byte_d  = '0;
		cnt_d   = '0;
		last_d  = 1'b1;
		case (head.op)
			vc_pkg::OP_DECODE: begin
				done = 1'b1;
				if (over) begin
					emit   = 1'b1;
					kind_d = vc_pkg::KIND_ERROR;
					acc_d  = '0;
					gc_d   = '0;
				end else if (head.in_byte[vc_pkg::CONT_POS]) begin
					acc_d = acc_or;
					gc_d  = gc_q + 1'b1;
				end else begin
					emit    = 1'b1;
					kind_d  = vc_pkg::KIND_VALUE;
					value_d = decoded;
					cnt_d   = vc_pkg::CNT_W'(gc_q + vc_pkg::GC_W'(1));
					acc_d   = '0;
					gc_d    = '0;
				end
			end
			vc_pkg::OP_ENCODE: begin
				emit   = 1'b1;
				done   = enc_last;
				kind_d = vc_pkg::KIND_BYTE;
				byte_d = grp | (enc_last ? '0 : ~vc_pkg::GROUP_MASK);
				cnt_d  = vc_pkg::CNT_W'(k_q);
				last_d = enc_last;
				k_d    = enc_last ? '0 : k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign pop = step && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			gc_q        <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				acc_q <= acc_d;
				gc_q  <= gc_d;
				k_q   <= k_d;
			end
			if (step && emit) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			byte_q  <= byte_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.out_kind   = kind_q;
	assign results.out_value  = value_q;
	assign results.out_byte   = byte_q;
	assign results.byte_count = cnt_q;
	assign results.last       = last_q;

`ifndef SYNTHESIS
	a_gc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gc_q <= vc_pkg::GC_W'(vc_pkg::MAX_GROUPS))
		else $error("group count above limit");
	a_enc_index: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) |-> (head_valid && head.op == vc_pkg::OP_ENCODE
			&& k_q < head.nbytes))
		else $error("encode index without encode command");
	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && head.op == vc_pkg::OP_DECODE && over)
			|=> (gc_q == '0 && res_valid_q && kind_q == vc_pkg::KIND_ERROR))
		else $error("overlength did not clear decoder");
`endif

endmodule

FILE: design/varint_codec_unit.sv
`timescale 1ns / 1ps
// Top level of the 7-bit group varint codec (LEB128 style, 32-bit, optional zigzag on decode).
// Depends on vc_pkg, vc_if, vc_front, vc_queue and vc_back.
//
// A decode word carries one encoded byte and yields a result word only when the
// value ends (or on an overlength error). An encode word carries a 32-bit value
// and yields 1 to 5 bytes, one per cycle while results are not stalled, so it
// occupies the back end until its last byte is emitted. The back end and
// its single output register set the rate; a four-entry command queue lets the
// input side keep accepting words while results wait. signed_mode is taken from
// its register when a value ends and may be written only while the block is idle.
module varint_codec_unit (
	input  logic       clk,
	input  logic       arst_n,
	vc_in_if.sink      items,
	vc_out_if.source   results,
	vc_cfg_if.sink     cfg
);

	logic         signed_mode_q;
	logic         full;
	logic         push;
	vc_pkg::cmd_t push_cmd;
	logic         pop;
	logic         head_valid;
	vc_pkg::cmd_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			signed_mode_q <= cfg.signed_mode;
		end
	end

	vc_front u_front (
		.items    (items),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	vc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.signed_mode (signed_mode_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.results     (results)
	);

endmodule
